// ----- rtl/ies_pkg.sv -----
// Shared types and constants for the image exposure scorer.
// No dependencies; imported by every module of the block except ies_ram.
package ies_pkg;

    // gray level format
    localparam int GRAY_LEVELS = 256;
    localparam int GRAY_W      = 8;
    localparam int SUM3_W      = 10;    // red + green + blue
    // floor(x / 3) as (x * 683) >> 11, exact for x below 2048
    localparam int RECIP_3     = 683;
    localparam int RECIP_SHIFT = 11;

    // score format: signed, 10 fraction bits
    localparam int SCORE_W   = 12;
    localparam int SCORE_ONE = 1024;

    // serial multiply / divide unit
    localparam int STEP_W = 6;

    typedef enum logic {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic                start;
        t_mdu_op             op;
        logic [STEP_W-1:0]   steps;
    } t_mdu_req;

endpackage

// ----- rtl/ies_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the gray level histogram.
module ies_ram #(
    parameter int W = 17,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write, and read the old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ies_mdu.sv -----
// Serial multiply / divide unit: one shift-add or compare-subtract per cycle.
// Depends on ies_pkg for the request struct and operation codes.
module ies_mdu
    import ies_pkg::*;
#(
    parameter int W = 50
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mdu_req     i_req,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_done,
    output logic [W-1:0] o_res
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_left;
    t_mdu_op           r_op;
    logic [W-1:0]      r_acc;
    logic [W-1:0]      r_x;
    logic [W-1:0]      r_y;

    logic [W-1:0] add_res;
    logic [W-1:0] sub_res;
    logic         ge;

    assign add_res = r_acc + r_x;
    assign sub_res = r_acc - r_x;
    assign ge      = (r_acc >= r_x);

    // load on start, then step until the count runs out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
            r_op   <= MDU_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_left <= i_req.steps;
                r_op   <= i_req.op;
                unique case (i_req.op)
                    MDU_MUL: begin
                        r_acc <= '0;
                        r_x   <= i_a;
                        r_y   <= i_b;
                    end
                    MDU_DIV: begin
                        r_acc <= i_a;
                        r_x   <= i_b;
                        r_y   <= '0;
                    end
                    default: begin
                        r_acc <= '0;
                        r_x   <= '0;
                        r_y   <= '0;
                    end
                endcase
            end else if (r_busy) begin
                r_left <= r_left - STEP_W'(1);
                if (r_left == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                unique case (r_op)
                    MDU_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= add_res;
                        end
                        r_x <= {r_x[W-2:0], 1'b0};
                        r_y <= {1'b0, r_y[W-1:1]};
                    end
                    MDU_DIV: begin
                        if (ge) begin
                            r_acc <= sub_res;
                        end
                        r_y <= {r_y[W-2:0], ge};
                        r_x <= {1'b0, r_x[W-1:1]};
                    end
                    default: begin
                        r_x <= r_x;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == MDU_MUL) ? r_acc : r_y;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("mdu started while busy");

endmodule

// ----- rtl/ies_hist.sv -----
// Pixel front end: gray conversion, histogram read-modify-write, running sums,
// and the end-of-frame percentile walk that also clears the histogram.
// Depends on ies_pkg and ies_ram.
module ies_hist
    import ies_pkg::*;
#(
    parameter int MAX_PIXELS = 65536,
    localparam int CW = $clog2(MAX_PIXELS + 1),
    localparam int SW = CW + GRAY_W,
    localparam int QW = CW + 2 * GRAY_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [GRAY_W-1:0] i_red,
    input  logic [GRAY_W-1:0] i_green,
    input  logic [GRAY_W-1:0] i_blue,
    input  logic              i_last_pixel,
    output logic              o_job_vld,
    input  logic              i_job_rdy,
    output logic [CW-1:0]     o_n,
    output logic [SW-1:0]     o_s,
    output logic [QW-1:0]     o_q,
    output logic [GRAY_W-1:0] o_lo,
    output logic [GRAY_W-1:0] o_md,
    output logic [GRAY_W-1:0] o_hi
);

    localparam int AW   = $clog2(GRAY_LEVELS);
    localparam int CW5  = CW + 5;
    localparam int PW   = SUM3_W + SUM3_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_RUN,
        S_DRAIN,
        S_WALK,
        S_HAND
    } t_state;

    t_state             r_state;
    logic [AW:0]        r_idx;
    logic [CW-1:0]      r_cnt;
    logic [SW-1:0]      r_sum;
    logic [QW-1:0]      r_sq;
    // pipeline: stage a holds the component sum, stage b the gray level
    logic               r_a_vld;
    logic               r_a_last;
    logic [SUM3_W-1:0]  r_a_sum;
    logic               r_b_cnt;
    logic               r_b_last;
    logic [GRAY_W-1:0]  r_b_gray;
    // last histogram write, for the read that overlapped it
    logic               r_fw_vld;
    logic [AW-1:0]      r_fw_addr;
    logic [CW-1:0]      r_fw_data;
    // walk
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_addr;
    logic [CW-1:0]      r_cum;
    logic               r_got_lo;
    logic               r_got_md;
    logic               r_got_hi;
    logic [GRAY_W-1:0]  r_lo;
    logic [GRAY_W-1:0]  r_md;
    logic [GRAY_W-1:0]  r_hi;

    logic               accept;
    logic               room;
    logic [PW-1:0]      prod;
    logic [GRAY_W-1:0]  gray_a;
    logic [15:0]        sq_b;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [CW-1:0]      ram_rdata;
    logic [CW-1:0]      bin_old;
    logic [CW-1:0]      n_cum;
    logic [CW5-1:0]     cum20;
    logic [CW5-1:0]     cum2;
    logic [CW5-1:0]     cnt1;
    logic [CW5-1:0]     cnt19;
    logic               walk_issue;
    logic               walk_end;

    assign accept = i_valid && (r_state == S_RUN);
    assign o_stall = (r_state != S_RUN);
    assign room   = (r_cnt < CW'(MAX_PIXELS));

    // gray level as a reciprocal multiply
    assign prod   = PW'(r_a_sum) * PW'(RECIP_3);
    assign gray_a = prod[RECIP_SHIFT +: GRAY_W];
    assign sq_b   = 16'(r_b_gray) * 16'(r_b_gray);

    // take the bin from the write still in flight when addresses match
    assign bin_old = (r_fw_vld && (r_fw_addr == r_b_gray)) ? r_fw_data : ram_rdata;

    assign walk_issue = (r_state == S_WALK) && !r_idx[AW];
    assign walk_end   = r_rd_vld && (r_rd_addr == AW'(GRAY_LEVELS - 1));

    // percentile thresholds on the running cumulative count
    assign n_cum = r_cum + ram_rdata;
    assign cum20 = CW5'(n_cum) * CW5'(20);
    assign cum2  = CW5'(n_cum) << 1;
    assign cnt1  = CW5'(r_cnt);
    assign cnt19 = CW5'(r_cnt) * CW5'(19);

    // histogram port selection
    always_comb begin
        ram_raddr = (r_state == S_WALK) ? r_idx[AW-1:0] : gray_a;
        ram_we    = 1'b0;
        ram_waddr = r_b_gray;
        ram_wdata = bin_old + CW'(1);
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx[AW-1:0];
            ram_wdata = '0;
        end else if (r_rd_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_addr;
            ram_wdata = '0;
        end else if (r_b_cnt) begin
            ram_we    = 1'b1;
        end
    end

    ies_ram #(
        .W (CW),
        .D (GRAY_LEVELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // state, pipeline, sums and walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_sq     <= '0;
            r_a_vld  <= 1'b0;
            r_a_last <= 1'b0;
            r_b_cnt  <= 1'b0;
            r_b_last <= 1'b0;
            r_fw_vld <= 1'b0;
            r_rd_vld <= 1'b0;
            r_cum    <= '0;
            r_got_lo <= 1'b0;
            r_got_md <= 1'b0;
            r_got_hi <= 1'b0;
        end else begin
            // advance the pixel pipeline
            r_a_vld  <= accept && room;
            r_a_last <= accept && i_last_pixel;
            r_a_sum  <= SUM3_W'(i_red) + SUM3_W'(i_green) + SUM3_W'(i_blue);
            r_b_cnt  <= r_a_vld;
            r_b_last <= r_a_last;
            r_b_gray <= gray_a;
            r_fw_vld  <= r_b_cnt && !r_rd_vld && (r_state != S_CLEAR);
            r_fw_addr <= r_b_gray;
            r_fw_data <= bin_old + CW'(1);
            if (accept && room) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_a_vld) begin
                r_sum <= r_sum + SW'(gray_a);
            end
            if (r_b_cnt) begin
                r_sq <= r_sq + QW'(sq_b);
            end
            // walk read pipe
            r_rd_vld  <= walk_issue;
            r_rd_addr <= r_idx[AW-1:0];
            if (r_rd_vld) begin
                r_cum <= n_cum;
                if (!r_got_lo && (cum20 >= cnt1)) begin
                    r_lo     <= r_rd_addr;
                    r_got_lo <= 1'b1;
                end
                if (!r_got_md && (cum2 >= cnt1)) begin
                    r_md     <= r_rd_addr;
                    r_got_md <= 1'b1;
                end
                if (!r_got_hi && (cum20 >= cnt19)) begin
                    r_hi     <= r_rd_addr;
                    r_got_hi <= 1'b1;
                end
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + (AW + 1)'(1);
                    if (r_idx[AW-1:0] == AW'(GRAY_LEVELS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (accept && i_last_pixel) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_b_last) begin
                        r_idx    <= '0;
                        r_cum    <= '0;
                        r_got_lo <= 1'b0;
                        r_got_md <= 1'b0;
                        r_got_hi <= 1'b0;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_issue) begin
                        r_idx <= r_idx + (AW + 1)'(1);
                    end
                    if (walk_end) begin
                        r_state <= S_HAND;
                    end
                end
                S_HAND: begin
                    if (i_job_rdy) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_sq    <= '0;
                        r_state <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    assign o_job_vld = (r_state == S_HAND);
    assign o_n  = r_cnt;
    assign o_s  = r_sum;
    assign o_q  = r_sq;
    assign o_lo = r_lo;
    assign o_md = r_md;
    assign o_hi = r_hi;

    a_walk_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (!r_a_vld && !r_b_cnt))
        else $error("pixel update overlaps histogram walk");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_PIXELS))
        else $error("pixel count beyond frame limit");

    a_rd_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_WALK))
        else $error("walk read outside walk");

endmodule

// ----- rtl/ies_score.sv -----
// Frame scoring sequencer: variance tests, mean, piecewise score and rounding,
// driving the shared serial multiply / divide unit, plus the result register.
// Depends on ies_pkg and an ies_mdu instance at the top level.
module ies_score
    import ies_pkg::*;
#(
    parameter int MAX_PIXELS = 65536,
    localparam int CW = $clog2(MAX_PIXELS + 1),
    localparam int SW = CW + GRAY_W,
    localparam int QW = CW + 2 * GRAY_W,
    localparam int MW = (2 * CW + 16 > CW + 32) ? 2 * CW + 16 : CW + 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_vld,
    output logic                      o_job_rdy,
    input  logic [CW-1:0]             i_n,
    input  logic [SW-1:0]             i_s,
    input  logic [QW-1:0]             i_q,
    input  logic [GRAY_W-1:0]         i_lo,
    input  logic [GRAY_W-1:0]         i_md,
    input  logic [GRAY_W-1:0]         i_hi,
    output t_mdu_req                  o_req,
    output logic [MW-1:0]             o_mdu_a,
    output logic [MW-1:0]             o_mdu_b,
    input  logic                      i_mdu_done,
    input  logic [MW-1:0]             i_mdu_res,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [SCORE_W-1:0] o_exp_score,
    output logic [GRAY_W-1:0]         o_mean_gray,
    output logic [GRAY_W-1:0]         o_low_level,
    output logic [GRAY_W-1:0]         o_median_level,
    output logic [GRAY_W-1:0]         o_high_level,
    output logic [CW-1:0]             o_frame_pixels
);

    localparam int NW = CW + 22;        // signed score numerator
    localparam int DW = CW + 19;        // 1200 * 255 * n
    localparam int VW = MW + 5;
    localparam int MEAN_STEPS  = 8;
    localparam int SCORE_STEPS = 12;
    localparam int SPREAD_WIDE   = 153; // above 0.6 of full range
    localparam int SPREAD_NARROW = 76;  // below 0.3 of full range

    localparam logic signed [NW-1:0] K3   = NW'(3);
    localparam logic signed [NW-1:0] K4   = NW'(4);
    localparam logic signed [NW-1:0] K7   = NW'(7);
    localparam logic signed [NW-1:0] K10  = NW'(10);
    localparam logic signed [NW-1:0] K13  = NW'(13);
    localparam logic signed [NW-1:0] K15  = NW'(15);
    localparam logic signed [NW-1:0] K17  = NW'(17);
    localparam logic signed [NW-1:0] K20  = NW'(20);
    localparam logic signed [NW-1:0] K36  = NW'(36);
    localparam logic signed [NW-1:0] K40  = NW'(40);
    localparam logic signed [NW-1:0] K255 = NW'(255);
    localparam logic signed [SCORE_W-1:0] SC_MAX = SCORE_W'(SCORE_ONE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NQ,
        S_SS,
        S_NN,
        S_COND,
        S_MEAN,
        S_NUM,
        S_ADJ,
        S_CLAMP,
        S_DIV,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic                      r_launch;
    logic [CW-1:0]             r_n;
    logic [SW-1:0]             r_s;
    logic [QW-1:0]             r_q;
    logic [GRAY_W-1:0]         r_lo;
    logic [GRAY_W-1:0]         r_md;
    logic [GRAY_W-1:0]         r_hi;
    logic [MW-1:0]             r_nq;
    logic [MW-1:0]             r_nv;
    logic [MW-1:0]             r_nn;
    logic                      r_hcon;
    logic                      r_lcon;
    logic [DW-1:0]             r_den;
    logic [GRAY_W-1:0]         r_mean;
    logic signed [NW-1:0]      r_num;
    logic [NW-1:0]             r_x;
    logic signed [SCORE_W-1:0] r_sc;
    logic                      r_out_vld;
    logic signed [SCORE_W-1:0] r_o_score;
    logic [GRAY_W-1:0]         r_o_mean;
    logic [GRAY_W-1:0]         r_o_lo;
    logic [GRAY_W-1:0]         r_o_md;
    logic [GRAY_W-1:0]         r_o_hi;
    logic [CW-1:0]             r_o_n;

    logic [GRAY_W-1:0]         spread;
    logic signed [NW-1:0]      sv;
    logic signed [NW-1:0]      nsig;
    logic signed [NW-1:0]      tv;
    logic signed [NW-1:0]      s20;
    logic signed [NW-1:0]      bon;
    logic signed [NW-1:0]      num0;
    logic signed [NW-1:0]      adj;
    logic signed [NW-1:0]      gained;
    logic signed [NW-1:0]      dens;
    logic signed [NW-1:0]      clamped;
    logic [VW-1:0]             nv25;
    logic [VW-1:0]             nn9216;
    logic                      out_take;
    logic                      out_load;

    assign spread = (r_hi >= r_lo) ? (r_hi - r_lo) : '0;
    assign sv     = signed'(NW'(r_s));
    assign nsig   = signed'(NW'(r_n));
    assign tv     = nsig * K255;
    assign s20    = sv * K20;
    assign dens   = signed'(NW'(r_den));
    assign nv25   = VW'(r_nv) * VW'(25);
    assign nn9216 = VW'(r_nn) * VW'(9216);

    // piecewise numerator over the common denominator 120 * 255 * n
    always_comb begin
        bon = '0;
        if (r_hcon) begin
            bon = bon + tv * K3;
        end
        if (spread > GRAY_W'(SPREAD_WIDE)) begin
            bon = bon + tv * K3;
        end
        if (s20 < tv * K3) begin
            num0 = (sv * K10 - tv * K3) * K40;
        end else if (s20 < tv * K7) begin
            num0 = (s20 - tv * K7) * K15;
        end else if (s20 < tv * K13) begin
            num0 = (sv * K40 - tv * K20 + bon) * K4;
        end else if (s20 < tv * K17) begin
            num0 = (s20 - tv * K13) * K15;
        end else begin
            num0 = (sv * K10 - tv * K7) * K40;
        end
    end

    // low-contrast push away from zero, then the narrow-range gain
    always_comb begin
        adj = r_num;
        if (r_lcon) begin
            adj = (!r_num[NW-1] && (r_num != '0)) ? r_num + tv * K36 : r_num - tv * K36;
        end
        gained = (spread <= GRAY_W'(SPREAD_NARROW)) ? adj * K13 : adj * K10;
    end

    // clamp to plus or minus one
    always_comb begin
        clamped = r_num;
        if (r_num > dens) begin
            clamped = dens;
        end else if (r_num < -dens) begin
            clamped = -dens;
        end
    end

    // operands for the shared unit
    always_comb begin
        o_req.start = r_launch;
        o_req.op    = MDU_MUL;
        o_req.steps = STEP_W'(CW);
        o_mdu_a     = MW'(r_q);
        o_mdu_b     = MW'(r_n);
        case (r_state)
            S_SS: begin
                o_req.steps = STEP_W'(SW);
                o_mdu_a     = MW'(r_s);
                o_mdu_b     = MW'(r_s);
            end
            S_NN: begin
                o_mdu_a = MW'(r_n);
            end
            S_MEAN: begin
                o_req.op    = MDU_DIV;
                o_req.steps = STEP_W'(MEAN_STEPS);
                o_mdu_a     = MW'(r_s);
                o_mdu_b     = MW'(r_n) << (MEAN_STEPS - 1);
            end
            S_DIV: begin
                o_req.op    = MDU_DIV;
                o_req.steps = STEP_W'(SCORE_STEPS);
                o_mdu_a     = (MW'(r_x) << (SCORE_STEPS - 1)) + MW'(r_den);
                o_mdu_b     = MW'(r_den) << SCORE_STEPS;
            end
            default: begin
                o_req.op = MDU_MUL;
            end
        endcase
    end

    assign o_job_rdy = (r_state == S_IDLE);
    assign out_take  = r_out_vld && !i_stall;
    assign out_load  = (r_state == S_OUT) && (!r_out_vld || !i_stall);

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_launch  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_launch <= 1'b0;
            if (out_load) begin
                r_out_vld <= 1'b1;
                r_o_score <= r_sc;
                r_o_mean  <= r_mean;
                r_o_lo    <= r_lo;
                r_o_md    <= r_md;
                r_o_hi    <= r_hi;
                r_o_n     <= r_n;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_vld) begin
                        r_n      <= i_n;
                        r_s      <= i_s;
                        r_q      <= i_q;
                        r_lo     <= i_lo;
                        r_md     <= i_md;
                        r_hi     <= i_hi;
                        r_launch <= 1'b1;
                        r_state  <= S_NQ;
                    end
                end
                S_NQ: begin
                    if (i_mdu_done) begin
                        r_nq     <= i_mdu_res;
                        r_launch <= 1'b1;
                        r_state  <= S_SS;
                    end
                end
                S_SS: begin
                    if (i_mdu_done) begin
                        r_nv     <= r_nq - i_mdu_res;
                        r_launch <= 1'b1;
                        r_state  <= S_NN;
                    end
                end
                S_NN: begin
                    if (i_mdu_done) begin
                        r_nn    <= i_mdu_res;
                        r_state <= S_COND;
                    end
                end
                S_COND: begin
                    r_hcon   <= (r_nv > (r_nn << 10));
                    r_lcon   <= (nv25 < nn9216);
                    r_den    <= DW'(r_n) * DW'(306000);
                    r_launch <= 1'b1;
                    r_state  <= S_MEAN;
                end
                S_MEAN: begin
                    if (i_mdu_done) begin
                        r_mean  <= i_mdu_res[GRAY_W-1:0];
                        r_state <= S_NUM;
                    end
                end
                S_NUM: begin
                    r_num   <= num0;
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_num   <= gained;
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_x      <= NW'(clamped + dens);
                    r_launch <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (i_mdu_done) begin
                        r_sc    <= signed'(i_mdu_res[SCORE_W-1:0] - SCORE_W'(SCORE_ONE));
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_out_vld;
    assign o_exp_score    = r_o_score;
    assign o_mean_gray    = r_o_mean;
    assign o_low_level    = r_o_lo;
    assign o_median_level = r_o_md;
    assign o_high_level   = r_o_hi;
    assign o_frame_pixels = r_o_n;

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_o_score <= SC_MAX) && (r_o_score >= -SC_MAX)))
        else $error("score outside plus or minus one");

endmodule

// ----- rtl/image_exposure_scorer.sv -----
// Top level of the image exposure scorer: pixel front end, scoring sequencer
// and shared serial multiply / divide unit. Depends on ies_pkg and all ies_ modules.
//
//  port group   dir  handshake            payload
//  pixel in     in   i_valid / o_stall    i_red, i_green, i_blue, i_last_pixel
//  score out    out  o_valid / i_stall    o_exp_score, o_mean_gray, o_low_level,
//                                         o_median_level, o_high_level, o_frame_pixels
//
// Pixels are taken one per cycle while o_stall is low; a histogram RAM
// read-modify-write with one forwarding register lets the same bin be hit on
// consecutive cycles. After a last pixel the input stalls while the pipeline
// drains, during a 256-bin walk that reads and zeroes the RAM, and during the
// hand-over until the scorer is free. Scoring then runs in the serial multiply /
// divide unit, overlapping the next frame's pixels.
// After reset the input stalls while the histogram is cleared.
// A result held by i_stall stays in the output register; a second frame's
// hand-over waits until the scorer is free.
module image_exposure_scorer
    import ies_pkg::*;
#(
    parameter int MAX_PIXELS = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [GRAY_W-1:0]                      i_red,
    input  logic [GRAY_W-1:0]                      i_green,
    input  logic [GRAY_W-1:0]                      i_blue,
    input  logic                                   i_last_pixel,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [SCORE_W-1:0]              o_exp_score,
    output logic [GRAY_W-1:0]                      o_mean_gray,
    output logic [GRAY_W-1:0]                      o_low_level,
    output logic [GRAY_W-1:0]                      o_median_level,
    output logic [GRAY_W-1:0]                      o_high_level,
    output logic [$clog2(MAX_PIXELS + 1)-1:0]      o_frame_pixels
);

    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int SW = CW + GRAY_W;
    localparam int QW = CW + 2 * GRAY_W;
    localparam int MW = (2 * CW + 16 > CW + 32) ? 2 * CW + 16 : CW + 32;

    logic              job_vld;
    logic              job_rdy;
    logic [CW-1:0]     job_n;
    logic [SW-1:0]     job_s;
    logic [QW-1:0]     job_q;
    logic [GRAY_W-1:0] job_lo;
    logic [GRAY_W-1:0] job_md;
    logic [GRAY_W-1:0] job_hi;
    t_mdu_req          mdu_req;
    logic [MW-1:0]     mdu_a;
    logic [MW-1:0]     mdu_b;
    logic              mdu_done;
    logic [MW-1:0]     mdu_res;

    ies_hist #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_hist (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .o_job_vld    (job_vld),
        .i_job_rdy    (job_rdy),
        .o_n          (job_n),
        .o_s          (job_s),
        .o_q          (job_q),
        .o_lo         (job_lo),
        .o_md         (job_md),
        .o_hi         (job_hi)
    );

    ies_mdu #(
        .W (MW)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .i_a     (mdu_a),
        .i_b     (mdu_b),
        .o_done  (mdu_done),
        .o_res   (mdu_res)
    );

    ies_score #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_score (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_vld      (job_vld),
        .o_job_rdy      (job_rdy),
        .i_n            (job_n),
        .i_s            (job_s),
        .i_q            (job_q),
        .i_lo           (job_lo),
        .i_md           (job_md),
        .i_hi           (job_hi),
        .o_req          (mdu_req),
        .o_mdu_a        (mdu_a),
        .o_mdu_b        (mdu_b),
        .i_mdu_done     (mdu_done),
        .i_mdu_res      (mdu_res),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_exp_score    (o_exp_score),
        .o_mean_gray    (o_mean_gray),
        .o_low_level    (o_low_level),
        .o_median_level (o_median_level),
        .o_high_level   (o_high_level),
        .o_frame_pixels (o_frame_pixels)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for image_exposure_scorer: directed frames, then random frames.
// It uses its own exposure predictor. Depends on ies_pkg and the image_exposure_scorer RTL.
module tb;
    import ies_pkg::*;

    localparam int FRAME_CAP  = 65536;
    localparam int RAND_ITEMS = 1700;
    localparam int HOLD_LEN   = 2000;
    localparam int DRAIN_WAIT = 700;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [7:0]                mean;
        logic [7:0]                lo;
        logic [7:0]                md;
        logic [7:0]                hi;
        logic [16:0]               npix;
    } score_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       last;
        logic       typed;
        score_t     want;
    } row_t;

    // directed pixels; rows with typed set carry their result
    localparam int NROWS = 22;
    localparam row_t DIRECTED [NROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, '{-12'sd1024, 8'd0, 8'd0, 8'd0, 8'd0, 17'd1}},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1,
            '{12'sd1024, 8'd255, 8'd255, 8'd255, 8'd255, 17'd1}},
        '{8'd255, 8'd255, 8'd254, 1'b1, 1'b0, '0},
        '{8'd1,   8'd1,   8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{8'd255, 8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{8'd128, 8'd127, 8'd129, 1'b1, 1'b0, '0},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b1, 1'b0, '0},
        '{8'd100, 8'd100, 8'd100, 1'b0, 1'b0, '0},
        '{8'd100, 8'd100, 8'd100, 1'b0, 1'b0, '0},
        '{8'd101, 8'd100, 8'd100, 1'b1, 1'b0, '0},
        '{8'd200, 8'd200, 8'd200, 1'b0, 1'b0, '0},
        '{8'd190, 8'd190, 8'd190, 1'b1, 1'b0, '0},
        '{8'd40,  8'd40,  8'd40,  1'b0, 1'b0, '0},
        '{8'd60,  8'd60,  8'd60,  1'b1, 1'b0, '0},
        '{8'd255, 8'd0,   8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   8'd255, 8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 1'b0, 1'b0, '0},
        '{8'd170, 8'd170, 8'd170, 1'b1, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [7:0] i_red = '0, i_green = '0, i_blue = '0;
    logic i_last_pixel = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [SCORE_W-1:0] o_exp_score;
    logic [7:0] o_mean_gray, o_low_level, o_median_level, o_high_level;
    logic [16:0] o_frame_pixels;

    image_exposure_scorer #(.MAX_PIXELS(FRAME_CAP)) dut (.*);

    always #6 i_clk = ~i_clk;

    // frame statistics as the predictor sees them
    longint unsigned gray_bins [GRAY_LEVELS];
    longint          frame_sum, frame_sq, frame_cnt;
    score_t          pending_scores [$];
    int              send_idle_pct, recv_idle_pct;
    int              mismatches, scores_seen, pixels_sent, frames_sent;
    bit              hold_go, hold_used, sending_done;
    int              hold_left;

    // absorb one pixel; on the last pixel work out the frame's score
    task automatic absorb_pixel(input logic [7:0] r, g, b, input logic last,
                                output bit done, output score_t res);
        longint gray, n, s, nv, t, num, den, p, cum, spread, lo, md, hi;
        bit got_lo, got_md, got_hi, high_con, low_con;
        int bonus;
        gray = (longint'(r) + g + b) / 3;
        done = 1'b0;
        res = '0;
        if (frame_cnt < FRAME_CAP) begin
            gray_bins[gray]++;
            frame_sum += gray;
            frame_sq += gray * gray;
            frame_cnt++;
        end
        if (!last) return;
        n = frame_cnt;
        s = frame_sum;
        cum = 0; lo = 0; md = 0; hi = 0;
        got_lo = 0; got_md = 0; got_hi = 0;
        for (int i = 0; i < GRAY_LEVELS; i++) begin
            cum += gray_bins[i];
            if (!got_lo && 20 * cum >= n) begin lo = i; got_lo = 1; end
            if (!got_md && 2 * cum >= n) begin md = i; got_md = 1; end
            if (!got_hi && 20 * cum >= 19 * n) begin hi = i; got_hi = 1; end
        end
        spread = (hi >= lo) ? hi - lo : 0;
        nv = n * frame_sq - s * s;
        high_con = nv > 1024 * n * n;
        low_con = 100 * nv < 36864 * n * n;
        t = 255 * n;
        // piecewise score over the mean
        if (20 * s < 3 * t)       num = (10 * s - 3 * t) * 40;
        else if (20 * s < 7 * t)  num = (20 * s - 7 * t) * 15;
        else if (20 * s < 13 * t) begin
            bonus = int'(high_con) + int'(5 * spread > 765);
            num = (40 * s - 20 * t + 3 * t * bonus) * 4;
        end
        else if (20 * s < 17 * t) num = (20 * s - 13 * t) * 15;
        else                      num = (10 * s - 7 * t) * 40;
        if (low_con) num = (num > 0) ? num + 36 * t : num - 36 * t;
        den = 1200 * t;
        num = (10 * spread < 765) ? num * 13 : num * 10;
        if (num > den) num = den;
        if (num < -den) num = -den;
        p = num * 1024 + 1024 * den;
        res.score = SCORE_W'((2 * p + den) / (2 * den) - 1024);
        res.mean = 8'(s / n);
        res.lo = 8'(lo);
        res.md = 8'(md);
        res.hi = 8'(hi);
        res.npix = 17'(n);
        done = 1'b1;
        foreach (gray_bins[i]) gray_bins[i] = 0;
        frame_sum = 0; frame_sq = 0; frame_cnt = 0;
    endtask

    // offer one pixel, idling first at random; hold it until the transfer
    task automatic send_pixel(input logic [7:0] r, g, b, input logic last,
                              input bit typed, input score_t typed_res);
        bit done;
        score_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red <= r; i_green <= g; i_blue <= b; i_last_pixel <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        absorb_pixel(r, g, b, last, done, res);
        if (done) begin
            pending_scores.push_back(typed ? typed_res : res);
            frames_sent++;
        end
        pixels_sent++;
    endtask

    function automatic logic [7:0] clip_level(input int v);
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
    endfunction

    // random frame; the shape decides which branch of the score is hit
    task automatic send_random_frame();
        int len, shape, base, width, lvl;
        logic [7:0] r, g, b;
        len = ($urandom_range(9) == 0) ? $urandom_range(200, 30) : $urandom_range(24, 1);
        shape = $urandom_range(3);
        base = $urandom_range(255);
        width = (shape == 1) ? $urandom_range(8) : $urandom_range(128);
        for (int k = 0; k < len; k++) begin
            if (shape == 0) begin
                r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            end
            else begin
                if (shape == 2) lvl = $urandom_range(1) ? base : 255 - base;
                else lvl = base + int'($urandom_range(2 * width)) - width;
                r = clip_level(lvl + int'($urandom_range(6)) - 3);
                g = clip_level(lvl + int'($urandom_range(6)) - 3);
                b = clip_level(lvl + int'($urandom_range(6)) - 3);
            end
            send_pixel(r, g, b, k == len - 1, 1'b0, '0);
        end
    endtask

    // compare one field, report the first few differences
    function automatic void check_field(input string name, input longint want, got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // check each result transfer against the oldest pending score
    always @(posedge i_clk) begin
        score_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            scores_seen++;
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer");
            end
            else begin
                want = pending_scores.pop_front();
                check_field("exp_score", want.score, o_exp_score);
                check_field("mean_gray", want.mean, o_mean_gray);
                check_field("low_level", want.lo, o_low_level);
                check_field("median_level", want.md, o_median_level);
                check_field("high_level", want.hi, o_high_level);
                check_field("frame_pixels", want.npix, o_frame_pixels);
            end
        end
    end

    // drive the output stall: random, or a long hold-off once when asked
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end
        else if (hold_go && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_LEN;
            i_stall <= 1'b1;
        end
        else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        #(12 * 3000000);
        $display("image_exposure_scorer regression: fail");
        $finish;
    end

    initial begin
        foreach (gray_bins[i]) gray_bins[i] = 0;
        frame_sum = 0; frame_sq = 0; frame_cnt = 0;
        send_idle_pct = 28; recv_idle_pct = 75;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_pixel(DIRECTED[i].r, DIRECTED[i].g, DIRECTED[i].b, DIRECTED[i].last,
                       DIRECTED[i].typed, DIRECTED[i].want);

        // random frames over three idling phases
        while (pixels_sent < RAND_ITEMS / 3) send_random_frame();
        send_idle_pct = 75; recv_idle_pct = 28;
        while (pixels_sent < 2 * RAND_ITEMS / 3) send_random_frame();
        send_idle_pct = 0; recv_idle_pct = 0;
        hold_go = 1'b1;
        while (pixels_sent < RAND_ITEMS) send_random_frame();
        i_valid <= 1'b0;

        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d pixels in %0d frames, %0d scores checked, %0d mismatches",
                 pixels_sent, frames_sent, scores_seen, mismatches);
        if (mismatches == 0 && pending_scores.size() == 0)
            $display("image_exposure_scorer regression: pass");
        else
            $display("image_exposure_scorer regression: fail");
        $finish;
    end

endmodule
